[design/rot_pkg.sv]
`timescale 1ns / 1ps

package rot_pkg;

    // Room states
    localparam logic [2:0] ST_VACANT = 3'd0;
    localparam logic [2:0] ST_DOOR   = 3'd1;
    localparam logic [2:0] ST_GUEST  = 3'd2;
    localparam logic [2:0] ST_HOUSE  = 3'd3;
    localparam logic [2:0] ST_MAINT  = 3'd4;
    localparam logic [2:0] ST_UNEXP  = 3'd5;

    // Profiles
    localparam logic [1:0] PR_UNKNOWN = 2'd0;
    localparam logic [1:0] PR_GUEST   = 2'd1;
    localparam logic [1:0] PR_HOUSE   = 2'd2;
    localparam logic [1:0] PR_MAINT   = 2'd3;

    // Configuration register indexes
    localparam int          CFG_IDX_W        = 3;
    localparam int          CFG_DATA_W       = 27;
    localparam logic [2:0]  REG_DOOR_AJAR    = 3'd0;
    localparam logic [2:0]  REG_ENTRY_TMO    = 3'd1;
    localparam logic [2:0]  REG_GUEST_ABS    = 3'd2;
    localparam logic [2:0]  REG_HOUSE_ABS    = 3'd3;
    localparam logic [2:0]  REG_MAINT_ABS    = 3'd4;
    localparam logic [2:0]  REG_GUEST_ENTRY  = 3'd5;
    localparam logic [2:0]  REG_HOUSE_ENTRY  = 3'd6;

    // Reset values of the configuration registers
    localparam logic [26:0] RST_DOOR_AJAR    = 27'd60000;
    localparam logic [26:0] RST_ENTRY_TMO    = 27'd120000;
    localparam logic [26:0] RST_GUEST_ABS    = 27'd1800000;
    localparam logic [26:0] RST_HOUSE_ABS    = 27'd600000;
    localparam logic [26:0] RST_MAINT_ABS    = 27'd3600000;
    localparam logic [15:0] RST_GUEST_ENTRY  = 16'd3000;
    localparam logic [15:0] RST_HOUSE_ENTRY  = 16'd8000;

    // Debounce history: all ones means door settled open
    localparam logic [2:0]  HIST_MASK        = 3'b111;

    // Default depth of the front-to-back queue (2 or more)
    localparam int          QUEUE_DEPTH_DEF  = 2;

    typedef struct packed {
        logic [26:0] door_ajar_limit_ms;
        logic [26:0] entry_timeout_ms;
        logic [26:0] guest_absence_ms;
        logic [26:0] housekeeping_absence_ms;
        logic [26:0] maintenance_absence_ms;
        logic [15:0] guest_entry_limit_ms;
        logic [15:0] housekeeping_entry_limit_ms;
    } cfg_t;

    // Classified poll passed from front to back
    typedef struct packed {
        logic        door_level;
        logic        mot;
        logic        d_rise;
        logic        d_fall;
        logic        m_rise;
        logic [31:0] now_ms;
    } item_t;

    typedef struct packed {
        logic [2:0]  room_state;
        logic [1:0]  profile;
        logic        alarm;
        logic        room_changed;
        logic        door_settled;
        logic        motion;
        logic [31:0] stay_ms;
        logic [31:0] entry_delay_ms;
        logic [15:0] door_cycle_count;
        logic [15:0] motion_edge_count;
        logic [7:0]  unexpected_count;
    } res_t;

endpackage

[design/rot_front.sv]
`timescale 1ns / 1ps

module rot_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          door_raw,
    input  logic          motion_raw,
    input  logic [31:0]   now_ms,
    input  logic          q_full,
    output logic          q_push,
    output rot_pkg::item_t q_item
);
    import rot_pkg::*;

    logic [2:0] door_hist_reg, door_hist_next;
    logic [2:0] mot_hist_reg, mot_hist_next;
    logic       door_level_reg, door_level_next;
    logic       mot_prev_reg;
    logic       mot;
    logic       accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;
    assign q_push   = accept;

    // Shift in the new samples
    assign door_hist_next = {door_hist_reg[1:0], door_raw};
    assign mot_hist_next  = {mot_hist_reg[1:0], motion_raw};

    // Door: three agreeing samples; motion: two of three
    always_comb
    begin
        if (door_hist_next == HIST_MASK)
            door_level_next = 1'b1;
        else if (door_hist_next == 3'b000)
            door_level_next = 1'b0;
        else
            door_level_next = door_level_reg;
    end

    assign mot = (mot_hist_next[0] & mot_hist_next[1]) |
                 (mot_hist_next[0] & mot_hist_next[2]) |
                 (mot_hist_next[1] & mot_hist_next[2]);

    // Edge classification
    always_comb
    begin
        q_item.door_level = door_level_next;
        q_item.mot        = mot;
        q_item.d_rise     = !door_level_reg && door_level_next;
        q_item.d_fall     = door_level_reg && !door_level_next;
        q_item.m_rise     = !mot_prev_reg && mot;
        q_item.now_ms     = now_ms;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            door_hist_reg  <= 3'b000;
            mot_hist_reg   <= 3'b000;
            door_level_reg <= 1'b0;
            mot_prev_reg   <= 1'b0;
        end
        else if (accept)
        begin
            door_hist_reg  <= door_hist_next;
            mot_hist_reg   <= mot_hist_next;
            door_level_reg <= door_level_next;
            mot_prev_reg   <= mot;
        end
    end

endmodule

[design/rot_queue.sv]
`timescale 1ns / 1ps

module rot_queue #(
    parameter int DEPTH = rot_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  rot_pkg::item_t push_item,
    output logic           full,
    output logic           not_empty,
    input  logic           pop,
    output rot_pkg::item_t head_item
);
    import rot_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t             store_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_item = store_reg[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_ptr_reg] <= push_item;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

[design/rot_back.sv]
`timescale 1ns / 1ps

module rot_back (
    input  logic           clk,
    input  logic           rst_n,
    input  rot_pkg::cfg_t  cfg,
    input  logic           q_valid,
    input  rot_pkg::item_t q_item,
    output logic           q_pop,
    output logic           out_valid,
    input  logic           out_ready,
    output rot_pkg::res_t  res
);
    import rot_pkg::*;

    logic [2:0]  state_reg, state_next;
    logic [1:0]  profile_reg, profile_next;
    logic        alarm_reg, alarm_next;
    logic [31:0] open_stamp_reg, open_stamp_next;
    logic [31:0] last_motion_reg, last_motion_next;
    logic [31:0] entry_time_reg, entry_time_next;
    logic [31:0] stay_reg, stay_next;
    logic [31:0] entry_delay_reg, entry_delay_next;
    logic [15:0] door_cycles_reg, door_cycles_next;
    logic [15:0] motion_events_reg, motion_events_next;
    logic [7:0]  unexp_events_reg, unexp_events_next;
    logic        changed_reg;
    logic        settled_reg;
    logic        motion_reg;
    logic        out_valid_reg;

    logic [31:0] open_for;
    logic [31:0] quiet_for;
    logic [31:0] stay_now;
    logic [26:0] absence_limit;
    logic        occ_timeout;

    // Take the next poll whenever the output slot is free or being emptied
    assign q_pop     = q_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;

    // Time differences, modulo 2^32
    assign open_for  = q_item.now_ms - open_stamp_reg;
    assign quiet_for = q_item.now_ms - last_motion_reg;
    assign stay_now  = q_item.now_ms - entry_time_reg;

    // Absence limit of the occupied state
    always_comb
    begin
        case (state_reg)
            ST_GUEST: absence_limit = cfg.guest_absence_ms;
            ST_HOUSE: absence_limit = cfg.housekeeping_absence_ms;
            default:  absence_limit = cfg.maintenance_absence_ms;
        endcase
    end

    assign occ_timeout = !q_item.mot && (quiet_for > {5'd0, absence_limit});

    // Room state machine
    always_comb
    begin
        state_next          = state_reg;
        profile_next        = profile_reg;
        alarm_next          = alarm_reg;
        open_stamp_next     = open_stamp_reg;
        last_motion_next    = last_motion_reg;
        entry_time_next     = entry_time_reg;
        stay_next           = stay_reg;
        entry_delay_next    = entry_delay_reg;
        door_cycles_next    = door_cycles_reg;
        motion_events_next  = motion_events_reg;
        unexp_events_next   = unexp_events_reg;

        case (state_reg)
            ST_VACANT:
            begin
                if (q_item.d_rise)
                begin
                    state_next          = ST_DOOR;
                    open_stamp_next     = q_item.now_ms;
                    door_cycles_next    = door_cycles_reg + 16'd1;
                    alarm_next          = 1'b0;
                end
                else if (q_item.m_rise)
                begin
                    state_next        = ST_UNEXP;
                    last_motion_next  = q_item.now_ms;
                    unexp_events_next = unexp_events_reg + 8'd1;
                    alarm_next        = 1'b1;
                end
                else if (q_item.door_level)
                begin
                    // door found open without an edge
                    state_next          = ST_DOOR;
                    open_stamp_next     = q_item.now_ms;
                end
            end
            ST_DOOR:
            begin
                if (q_item.door_level && (open_for > {5'd0, cfg.door_ajar_limit_ms}))
                    alarm_next = 1'b1;
                if (q_item.m_rise)
                begin
                    entry_delay_next = open_for;
                    if (open_for < {16'd0, cfg.guest_entry_limit_ms})
                    begin
                        profile_next = PR_GUEST;
                        state_next   = ST_GUEST;
                    end
                    else if (open_for < {16'd0, cfg.housekeeping_entry_limit_ms})
                    begin
                        profile_next = PR_HOUSE;
                        state_next   = ST_HOUSE;
                    end
                    else
                    begin
                        profile_next = PR_MAINT;
                        state_next   = ST_MAINT;
                    end
                    motion_events_next = 16'd1;
                    entry_time_next    = q_item.now_ms;
                end
                else if (q_item.d_fall)
                begin
                    state_next = ST_VACANT;
                    alarm_next = 1'b0;
                end
                else if (!q_item.door_level)
                    state_next = ST_VACANT;     // alarm kept
                else if (open_for > {5'd0, cfg.entry_timeout_ms})
                    state_next = ST_VACANT;
            end
            ST_GUEST, ST_HOUSE, ST_MAINT:
            begin
                if (q_item.m_rise)
                    motion_events_next = motion_events_reg + 16'd1;
                if (q_item.mot)
                    last_motion_next = q_item.now_ms;
                else if (occ_timeout)
                    state_next = ST_VACANT;
                // maintenance also stamps the door closing
                if (q_item.d_rise || ((state_reg == ST_MAINT) && q_item.d_fall))
                    open_stamp_next = q_item.now_ms;
            end
            ST_UNEXP:
            begin
                alarm_next = 1'b1;
                if (q_item.d_rise)
                begin
                    state_next          = ST_DOOR;
                    open_stamp_next     = q_item.now_ms;
                    alarm_next          = 1'b0;
                end
                else if (!q_item.mot && (quiet_for > {5'd0, cfg.guest_absence_ms}))
                begin
                    state_next = ST_VACANT;
                    alarm_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_VACANT;
            end
        endcase

        // Any departure records the stay
        if ((state_next == ST_VACANT) && (state_reg != ST_VACANT))
            stay_next = stay_now;
    end

    // Room state, doubling as the output payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_VACANT;
            profile_reg        <= PR_UNKNOWN;
            alarm_reg          <= 1'b0;
            open_stamp_reg     <= '0;
            last_motion_reg    <= '0;
            entry_time_reg     <= '0;
            stay_reg           <= '0;
            entry_delay_reg    <= '0;
            door_cycles_reg    <= '0;
            motion_events_reg  <= '0;
            unexp_events_reg   <= '0;
        end
        else if (q_pop)
        begin
            state_reg          <= state_next;
            profile_reg        <= profile_next;
            alarm_reg          <= alarm_next;
            open_stamp_reg     <= open_stamp_next;
            last_motion_reg    <= last_motion_next;
            entry_time_reg     <= entry_time_next;
            stay_reg           <= stay_next;
            entry_delay_reg    <= entry_delay_next;
            door_cycles_reg    <= door_cycles_next;
            motion_events_reg  <= motion_events_next;
            unexp_events_reg   <= unexp_events_next;
        end
    end

    // Per-poll flags of the output transaction
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            changed_reg   <= (state_next != state_reg);
            settled_reg   <= q_item.door_level;
            motion_reg    <= q_item.mot;
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (q_pop)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_comb
    begin
        res.room_state         = state_reg;
        res.profile            = profile_reg;
        res.alarm              = alarm_reg;
        res.room_changed       = changed_reg;
        res.door_settled       = settled_reg;
        res.motion             = motion_reg;
        res.stay_ms            = stay_reg;
        res.entry_delay_ms     = entry_delay_reg;
        res.door_cycle_count   = door_cycles_reg;
        res.motion_edge_count  = motion_events_reg;
        res.unexpected_count   = unexp_events_reg;
    end

endmodule

[design/room_occupancy_tracker.sv]
`timescale 1ns / 1ps

// Channel   Handshake               Payload
// input     in_valid / in_ready     door_raw, motion_raw, now_ms
// output    out_valid / out_ready   room_state ... unexpected_count
// config    cfg_we (no wait)        cfg_index, cfg_data
//
// One poll per cycle sustained while out_ready holds; a poll is written into the
// queue at acceptance and registered by the back end when it is popped.
// Reset gives the documented register defaults and a vacant room.
// The queue holds QUEUE_DEPTH polls; in_ready drops only when it is full,
// which happens only while the output transaction is stalled.

module room_occupancy_tracker #(
    parameter int QUEUE_DEPTH = rot_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           door_raw,
    input  logic                           motion_raw,
    input  logic [31:0]                    now_ms,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [2:0]                     room_state,
    output logic [1:0]                     profile,
    output logic                           alarm,
    output logic                           room_changed,
    output logic                           door_settled,
    output logic                           motion,
    output logic [31:0]                    stay_ms,
    output logic [31:0]                    entry_delay_ms,
    output logic [15:0]                    door_cycle_count,
    output logic [15:0]                    motion_edge_count,
    output logic [7:0]                     unexpected_count,
    input  logic                           cfg_we,
    input  logic [rot_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rot_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rot_pkg::*;

    cfg_t  cfg_reg;
    item_t push_item;
    item_t head_item;
    res_t  res;
    logic  push;
    logic  q_full;
    logic  q_not_empty;
    logic  pop;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.door_ajar_limit_ms          <= RST_DOOR_AJAR;
            cfg_reg.entry_timeout_ms            <= RST_ENTRY_TMO;
            cfg_reg.guest_absence_ms            <= RST_GUEST_ABS;
            cfg_reg.housekeeping_absence_ms     <= RST_HOUSE_ABS;
            cfg_reg.maintenance_absence_ms      <= RST_MAINT_ABS;
            cfg_reg.guest_entry_limit_ms        <= RST_GUEST_ENTRY;
            cfg_reg.housekeeping_entry_limit_ms <= RST_HOUSE_ENTRY;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DOOR_AJAR:   cfg_reg.door_ajar_limit_ms          <= cfg_data;
                REG_ENTRY_TMO:   cfg_reg.entry_timeout_ms            <= cfg_data;
                REG_GUEST_ABS:   cfg_reg.guest_absence_ms            <= cfg_data;
                REG_HOUSE_ABS:   cfg_reg.housekeeping_absence_ms     <= cfg_data;
                REG_MAINT_ABS:   cfg_reg.maintenance_absence_ms      <= cfg_data;
                REG_GUEST_ENTRY: cfg_reg.guest_entry_limit_ms        <= cfg_data[15:0];
                REG_HOUSE_ENTRY: cfg_reg.housekeeping_entry_limit_ms <= cfg_data[15:0];
                default:         ;
            endcase
        end
    end

    // Debounce and edge classification
    rot_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .door_raw   (door_raw),
        .motion_raw (motion_raw),
        .now_ms     (now_ms),
        .q_full     (q_full),
        .q_push     (push),
        .q_item     (push_item)
    );

    rot_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .not_empty (q_not_empty),
        .pop       (pop),
        .head_item (head_item)
    );

    // Room machine and output register
    rot_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_not_empty),
        .q_item    (head_item),
        .q_pop     (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res)
    );

    assign room_state         = res.room_state;
    assign profile            = res.profile;
    assign alarm              = res.alarm;
    assign room_changed       = res.room_changed;
    assign door_settled       = res.door_settled;
    assign motion             = res.motion;
    assign stay_ms            = res.stay_ms;
    assign entry_delay_ms     = res.entry_delay_ms;
    assign door_cycle_count   = res.door_cycle_count;
    assign motion_edge_count  = res.motion_edge_count;
    assign unexpected_count   = res.unexpected_count;

    // A full queue can only build up behind a stalled output
    a_full_needs_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("queue full with no pending output");

    // Unexpected presence always carries the alarm
    a_unexp_alarm: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && room_state == ST_UNEXP) |-> alarm)
        else $error("unexpected state without alarm");

    // Entering an occupied state restarts the motion count at one
    a_entry_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && room_changed &&
         (room_state == ST_GUEST || room_state == ST_HOUSE || room_state == ST_MAINT))
        |-> (motion_edge_count == 16'd1))
        else $error("occupied entry with wrong motion count");

    // No classification yet means no entry delay and no motion events
    a_unknown_profile: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && profile == PR_UNKNOWN)
        |-> (entry_delay_ms == 32'd0 && motion_edge_count == 16'd0))
        else $error("unknown profile with occupancy data");

endmodule

[tb/sv/room_occupancy_tracker_tb.sv]
`timescale 1ns / 1ps

module room_occupancy_tracker_tb;

    import rot_pkg::*;

    // One sensor poll as presented on the input channel
    typedef struct packed {
        logic        door;
        logic        mot;
        logic [31:0] t;
    } poll_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        door_raw = 1'b0;
    logic        motion_raw = 1'b0;
    logic [31:0] now_ms = 32'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  room_state;
    logic [1:0]  profile;
    logic        alarm;
    logic        room_changed;
    logic        door_settled;
    logic        motion;
    logic [31:0] stay_ms;
    logic [31:0] entry_delay_ms;
    logic [15:0] door_cycle_count;
    logic [15:0] motion_edge_count;
    logic [7:0]  unexpected_count;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    room_occupancy_tracker dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .door_raw           (door_raw),
        .motion_raw         (motion_raw),
        .now_ms             (now_ms),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .room_state         (room_state),
        .profile            (profile),
        .alarm              (alarm),
        .room_changed       (room_changed),
        .door_settled       (door_settled),
        .motion             (motion),
        .stay_ms            (stay_ms),
        .entry_delay_ms     (entry_delay_ms),
        .door_cycle_count   (door_cycle_count),
        .motion_edge_count  (motion_edge_count),
        .unexpected_count   (unexpected_count),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    // Register shadow, as the block should hold it
    logic [31:0] cfg_shadow [7] = '{{5'd0, RST_DOOR_AJAR}, {5'd0, RST_ENTRY_TMO},
                                    {5'd0, RST_GUEST_ABS}, {5'd0, RST_HOUSE_ABS},
                                    {5'd0, RST_MAINT_ABS},
                                    {16'd0, RST_GUEST_ENTRY}, {16'd0, RST_HOUSE_ENTRY}};

    // Room model state
    logic [2:0]  door_hist = '0;
    logic [2:0]  mot_hist = '0;
    logic        door_lvl = 1'b0;
    logic        mot_prev = 1'b0;
    logic [2:0]  room_st = ST_VACANT;
    logic [1:0]  prof_st = PR_UNKNOWN;
    logic        alarm_st = 1'b0;
    logic [31:0] t_opened = '0;
    logic [31:0] t_last_mot = '0;
    logic [31:0] t_entry = '0;
    logic [31:0] stay_len = '0;
    logic [31:0] entry_dly = '0;
    logic [15:0] n_door = '0;
    logic [15:0] n_motion = '0;
    logic [7:0]  n_unexp = '0;
    logic [5:0]  states_seen = '0;

    poll_t       pending_polls[$];
    res_t        expected_reports[$];
    poll_t       poll_on_bus;
    logic [31:0] t_gen = '0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          n_polls = 0;
    int          n_checked = 0;
    int          n_mismatch = 0;
    int          n_settings = 1;
    logic [9:0]  rdy_cycle = '0;

    initial begin
        forever #5 clk = ~clk;
    end

    // Room behaviour for one poll; updates the model and returns the report
    function automatic res_t next_room_report(input logic d, input logic m,
                                              input logic [31:0] now);
        logic [2:0]  state_before;
        logic        prev_door;
        logic        mot;
        logic        d_rise;
        logic        d_fall;
        logic        m_rise;
        logic [31:0] open_for;
        logic [31:0] quiet_limit;
        res_t        r;
        state_before = room_st;
        prev_door  = door_lvl;

        // debounce: door needs three agreeing samples, motion two of three
        door_hist = {door_hist[1:0], d};
        mot_hist  = {mot_hist[1:0], m};
        if (door_hist == HIST_MASK)
            door_lvl = 1'b1;
        else if (door_hist == 3'b000)
            door_lvl = 1'b0;
        mot = (mot_hist[0] & mot_hist[1]) | (mot_hist[0] & mot_hist[2]) |
              (mot_hist[1] & mot_hist[2]);
        d_rise   = !prev_door && door_lvl;
        d_fall   = prev_door && !door_lvl;
        m_rise   = !mot_prev && mot;
        mot_prev = mot;
        open_for = now - t_opened;

        case (room_st)
            ST_VACANT:
            begin
                if (d_rise) begin
                    room_st     = ST_DOOR;
                    t_opened    = now;
                    n_door      = n_door + 16'd1;
                    alarm_st    = 1'b0;
                end else if (m_rise) begin
                    room_st    = ST_UNEXP;
                    t_last_mot = now;
                    n_unexp    = n_unexp + 8'd1;
                    alarm_st   = 1'b1;
                end else if (door_lvl) begin
                    room_st     = ST_DOOR;
                    t_opened    = now;
                end
            end
            ST_DOOR:
            begin
                if (door_lvl && open_for > cfg_shadow[REG_DOOR_AJAR])
                    alarm_st = 1'b1;
                if (m_rise) begin
                    // classify the entry delay, guest limit first
                    entry_dly = open_for;
                    if (open_for < cfg_shadow[REG_GUEST_ENTRY]) begin
                        prof_st = PR_GUEST;
                        room_st = ST_GUEST;
                    end else if (open_for < cfg_shadow[REG_HOUSE_ENTRY]) begin
                        prof_st = PR_HOUSE;
                        room_st = ST_HOUSE;
                    end else begin
                        prof_st = PR_MAINT;
                        room_st = ST_MAINT;
                    end
                    n_motion = 16'd1;
                    t_entry  = now;
                end else if (d_fall) begin
                    room_st  = ST_VACANT;
                    alarm_st = 1'b0;
                end else if (!door_lvl || open_for > cfg_shadow[REG_ENTRY_TMO]) begin
                    room_st = ST_VACANT;
                end
            end
            ST_GUEST, ST_HOUSE, ST_MAINT:
            begin
                if (room_st == ST_GUEST)
                    quiet_limit = cfg_shadow[REG_GUEST_ABS];
                else if (room_st == ST_HOUSE)
                    quiet_limit = cfg_shadow[REG_HOUSE_ABS];
                else
                    quiet_limit = cfg_shadow[REG_MAINT_ABS];
                if (m_rise) begin
                    n_motion   = n_motion + 16'd1;
                    t_last_mot = now;
                end
                if (mot)
                    t_last_mot = now;
                else if (now - t_last_mot > quiet_limit)
                    room_st = ST_VACANT;
                if (d_rise || (state_before == ST_MAINT && d_fall))
                    t_opened = now;
            end
            ST_UNEXP:
            begin
                alarm_st = 1'b1;
                if (d_rise) begin
                    room_st     = ST_DOOR;
                    t_opened    = now;
                    alarm_st    = 1'b0;
                end else if (!mot && now - t_last_mot > cfg_shadow[REG_GUEST_ABS]) begin
                    room_st  = ST_VACANT;
                    alarm_st = 1'b0;
                end
            end
            default:
                room_st = ST_VACANT;
        endcase

        // every departure records the stay
        if (room_st == ST_VACANT && state_before != ST_VACANT)
            stay_len = now - t_entry;
        states_seen[room_st] = 1'b1;

        r.room_state         = room_st;
        r.profile            = prof_st;
        r.alarm              = alarm_st;
        r.room_changed       = (room_st != state_before);
        r.door_settled       = door_lvl;
        r.motion             = mot;
        r.stay_ms            = stay_len;
        r.entry_delay_ms     = entry_dly;
        r.door_cycle_count   = n_door;
        r.motion_edge_count  = n_motion;
        r.unexpected_count   = n_unexp;
        return r;
    endfunction

    // Sender: bursts of random length separated by random gaps
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid   <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else if (!in_valid || in_ready) begin
            if (in_valid) begin
                expected_reports.push_back(next_room_report(poll_on_bus.door,
                                                            poll_on_bus.mot,
                                                            poll_on_bus.t));
                n_polls++;
            end
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (pending_polls.size() != 0) begin
                poll_on_bus = pending_polls.pop_front();
                in_valid   <= 1'b1;
                door_raw   <= poll_on_bus.door;
                motion_raw <= poll_on_bus.mot;
                now_ms     <= poll_on_bus.t;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left--;
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern chosen by the top bits of a free-running counter
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            rdy_cycle <= '0;
        end else begin
            rdy_cycle <= rdy_cycle + 10'd1;
            case (rdy_cycle[9:7])
                3'd0, 3'd1: out_ready <= 1'b1;
                3'd2:       out_ready <= 1'($urandom_range(0, 1));
                3'd3:       out_ready <= ($urandom_range(0, 3) == 0);
                3'd4:       out_ready <= rdy_cycle[2];
                default:    out_ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    task automatic check_field(input string nm, input logic [31:0] e,
                               input logic [31:0] a);
        if (a !== e) begin
            n_mismatch++;
            if (n_mismatch <= 10)
                $display("report %0d: %s expected %0h, got %0h", n_checked, nm, e, a);
        end
    endtask

    // Monitor: each output transaction against the oldest expectation
    always @(posedge clk) begin
        res_t exp_r;
        if (rst_n && out_valid && out_ready) begin
            if (expected_reports.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("report with no poll outstanding, state %0d", room_state);
            end else begin
                exp_r = expected_reports.pop_front();
                check_field("room_state", 32'(exp_r.room_state), 32'(room_state));
                check_field("profile", 32'(exp_r.profile), 32'(profile));
                check_field("alarm", 32'(exp_r.alarm), 32'(alarm));
                check_field("room_changed", 32'(exp_r.room_changed), 32'(room_changed));
                check_field("door_settled", 32'(exp_r.door_settled), 32'(door_settled));
                check_field("motion", 32'(exp_r.motion), 32'(motion));
                check_field("stay_ms", exp_r.stay_ms, stay_ms);
                check_field("entry_delay_ms", exp_r.entry_delay_ms, entry_delay_ms);
                check_field("door_cycle_count", 32'(exp_r.door_cycle_count),
                            32'(door_cycle_count));
                check_field("motion_edge_count", 32'(exp_r.motion_edge_count),
                            32'(motion_edge_count));
                check_field("unexpected_count", 32'(exp_r.unexpected_count),
                            32'(unexpected_count));
            end
            n_checked++;
        end
    end

    // Stimulus helpers
    task automatic add_poll(input logic d, input logic m, input logic [31:0] dt);
        t_gen = t_gen + dt;
        pending_polls.push_back('{door: d, mot: m, t: t_gen});
    endtask

    // a delay just under, at, or just over a limit, anywhere up to twice it, or one of at most 3
    function automatic logic [31:0] near_limit(input logic [31:0] lim);
        case ($urandom_range(0, 4))
            0:       return (lim == 0) ? 32'd0 : lim - 32'd1;
            1:       return lim;
            2:       return lim + 32'd1;
            3:       return $urandom_range(0, lim * 2);
            default: return $urandom_range(0, 3);
        endcase
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [26:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == REG_GUEST_ENTRY || idx == REG_HOUSE_ENTRY)
            cfg_shadow[idx] = {16'd0, val[15:0]};
        else
            cfg_shadow[idx] = {5'd0, val};
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_all(input logic [26:0] ajar, input logic [26:0] entry_tmo,
                             input logic [26:0] g_abs, input logic [26:0] h_abs,
                             input logic [26:0] m_abs, input logic [26:0] g_entry,
                             input logic [26:0] h_entry);
        write_reg(REG_DOOR_AJAR, ajar);
        write_reg(REG_ENTRY_TMO, entry_tmo);
        write_reg(REG_GUEST_ABS, g_abs);
        write_reg(REG_HOUSE_ABS, h_abs);
        write_reg(REG_MAINT_ABS, m_abs);
        write_reg(REG_GUEST_ENTRY, g_entry);
        write_reg(REG_HOUSE_ENTRY, h_entry);
        n_settings++;
    endtask

    // wait until every poll has been sent and its report seen
    task automatic wait_idle();
        while (pending_polls.size() != 0 || in_valid || expected_reports.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    // A full stay: door opens, someone enters, moves about, then goes quiet
    task automatic gen_visit();
        logic [31:0] lim;
        logic [31:0] quiet;
        logic        d;
        case ($urandom_range(0, 2))
            0:       quiet = cfg_shadow[REG_GUEST_ABS];
            1:       quiet = cfg_shadow[REG_HOUSE_ABS];
            default: quiet = cfg_shadow[REG_MAINT_ABS];
        endcase
        case ($urandom_range(0, 3))
            0:       lim = cfg_shadow[REG_GUEST_ENTRY];
            1:       lim = cfg_shadow[REG_HOUSE_ENTRY];
            2:       lim = cfg_shadow[REG_DOOR_AJAR];
            default: lim = cfg_shadow[REG_ENTRY_TMO];
        endcase
        repeat ($urandom_range(1, 3)) add_poll(1'b0, 1'b0, $urandom_range(0, 3));
        repeat (3) add_poll(1'b1, 1'b0, $urandom_range(0, 3));
        // motion settles on the second sample, so the delay is exact
        add_poll(1'b1, 1'b1, near_limit(lim));
        add_poll(1'($urandom_range(0, 1)), 1'b1, 32'd0);
        d = 1'b1;
        repeat ($urandom_range(2, 8)) begin
            if ($urandom_range(0, 3) == 0)
                d = ~d;
            add_poll(d, 1'($urandom_range(0, 1)), $urandom_range(0, quiet / 4));
        end
        add_poll(d, 1'b0, 32'd0);
        add_poll(d, 1'b0, 32'd0);
        add_poll(d, 1'b0, near_limit(quiet));
        repeat ($urandom_range(1, 3)) add_poll(1'b0, 1'b0, $urandom_range(0, 3));
    endtask

    // Motion with no door: an intruder who leaves quietly or opens the door
    task automatic gen_stray();
        add_poll(1'b0, 1'b1, $urandom_range(0, 3));
        add_poll(1'b0, 1'b1, $urandom_range(0, 3));
        add_poll(1'b0, 1'b0, 32'd0);
        add_poll(1'b0, 1'b0, 32'd0);
        if ($urandom_range(0, 1) == 0) begin
            add_poll(1'b0, 1'b0, near_limit(cfg_shadow[REG_GUEST_ABS]));
        end else begin
            repeat (3) add_poll(1'b1, 1'b0, $urandom_range(0, 3));
            repeat ($urandom_range(1, 3))
                add_poll(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         $urandom_range(0, 3));
        end
    endtask

    task automatic gen_phase(input int n);
        logic [31:0] dt;
        t_gen = $urandom;
        while (pending_polls.size() < n) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: gen_visit();
                6:                gen_stray();
                default:
                begin
                    // noise: raw bits at random with arbitrary time steps
                    repeat ($urandom_range(1, 6)) begin
                        case ($urandom_range(0, 3))
                            0:       dt = $urandom;
                            1:       dt = $urandom_range(0, 3);
                            default: dt = near_limit(cfg_shadow[3'($urandom_range(0, 6))]);
                        endcase
                        add_poll(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), dt);
                    end
                end
            endcase
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed walk at reset limits, with the clock wrapping mid-stay
        @(negedge clk);
        t_gen = 32'hFFFF_F000;
        add_poll(1'b0, 1'b0, 32'd0);
        add_poll(1'b1, 1'b0, 32'd10);               // lone door sample is ignored
        add_poll(1'b0, 1'b0, 32'd10);
        repeat (3) add_poll(1'b1, 1'b0, 32'd10);    // door opens from vacant
        add_poll(1'b1, 1'b1, 32'd2000);
        add_poll(1'b1, 1'b1, 32'd10);               // quick entry: guest
        repeat (3) add_poll(1'b0, 1'b0, 32'd10);
        add_poll(1'b0, 1'b0, 32'd1800001);          // guest gone quiet
        add_poll(1'b0, 1'b1, 32'd10);
        add_poll(1'b0, 1'b1, 32'd10);               // motion in an empty room
        repeat (3) add_poll(1'b1, 1'b0, 32'd10);    // door opened from unexpected
        add_poll(1'b1, 1'b0, 32'd60001);            // door held open: alarm
        add_poll(1'b1, 1'b0, 32'd60001);            // entry timeout, alarm kept
        add_poll(1'b1, 1'b0, 32'd10);               // door still open without an edge
        add_poll(1'b1, 1'b1, 32'd5000);
        add_poll(1'b1, 1'b1, 32'd10);               // slower entry: housekeeping
        repeat (2) add_poll(1'b0, 1'b0, 32'd10);
        add_poll(1'b0, 1'b0, 32'd600001);
        repeat (3) add_poll(1'b1, 1'b0, 32'd10);
        add_poll(1'b1, 1'b1, 32'd9000);
        add_poll(1'b1, 1'b1, 32'd0);                // slow entry: maintenance
        wait_idle();

        // Short limits so that every timeout is reached quickly
        write_all(27'd50, 27'd100, 27'd300, 27'd200, 27'd400, 27'd20, 27'd60);
        @(negedge clk);
        gen_phase(80);
        wait_idle();

        // Smallest limits
        write_all(27'd1, 27'd1, 27'd1, 27'd1, 27'd1, 27'd0, 27'd0);
        @(negedge clk);
        gen_phase(80);
        wait_idle();

        // Largest limits; top bits beyond a 16-bit register are dropped
        write_all(27'h7FF_FFFF, 27'd86400000, 27'd86400000, 27'd86400000,
                  27'd86400000, 27'h7FF_FFFF, 27'd65535);
        @(negedge clk);
        gen_phase(80);
        wait_idle();

        // Zero limits and a guest limit above the housekeeping limit
        write_all(27'd0, 27'd0, 27'd0, 27'd5000, 27'd0, 27'd5000, 27'd1000);
        @(negedge clk);
        gen_phase(80);
        wait_idle();

        // Random limits, mostly short
        repeat (2) begin
            write_all(($urandom_range(0, 1) == 0) ? 27'($urandom_range(1, 86400000))
                                                  : 27'($urandom_range(1, 500)),
                      27'($urandom_range(1, 1000)), 27'($urandom_range(1, 3000)),
                      27'($urandom_range(1, 3000)), 27'($urandom_range(1, 3000)),
                      27'($urandom_range(0, 400)), 27'($urandom_range(0, 800)));
            @(negedge clk);
            gen_phase(80);
            wait_idle();
        end

        $display("Run covered %0d polls under %0d register settings, %0d reports checked.",
                 n_polls, n_settings, n_checked);
        $display("Room states reached (unexpected..vacant): %b, mismatches: %0d",
                 states_seen, n_mismatch);
        if (n_mismatch == 0 && expected_reports.size() == 0)
            $display("PASS room_occupancy_tracker");
        else
            $display("FAIL room_occupancy_tracker");
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #5_000_000;
        $display("Timed out with %0d polls pending and %0d reports outstanding",
                 pending_polls.size(), expected_reports.size());
        $display("FAIL room_occupancy_tracker");
        $finish;
    end

endmodule
